@@ rtl/dit_pkg.sv @@
// Shared types and constants for the disc index table parser.
// Used by the channel interfaces, the parser core, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dit_pkg;

   // Result kinds.
   localparam logic [2:0] KIND_FIRST_PLAY = 3'd0;
   localparam logic [2:0] KIND_TOP_MENU   = 3'd1;
   localparam logic [2:0] KIND_TITLE      = 3'd2;
   localparam logic [2:0] KIND_FINISHED   = 3'd3;
   localparam logic [2:0] KIND_ERROR      = 3'd4;

   // Error codes.
   localparam logic [2:0] ERR_MAGIC     = 3'd0;
   localparam logic [2:0] ERR_VERSION   = 3'd1;
   localparam logic [2:0] ERR_OFFSET    = 3'd2;
   localparam logic [2:0] ERR_OBJ_TYPE  = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;

   // Error code field of a result that is not an error.
   localparam logic [2:0] ERR_NONE      = 3'd0;

   // Version codes.
   localparam logic [1:0] VER_CODE_0100 = 2'd0;
   localparam logic [1:0] VER_CODE_0200 = 2'd1;
   localparam logic [1:0] VER_CODE_0300 = 2'd2;

   // Object types.
   localparam logic [1:0] OBJ_MOVIE = 2'b01;
   localparam logic [1:0] OBJ_APP   = 2'b10;

   // Header words: "INDX", "0100", "0200", "0300".
   localparam logic [31:0] MAGIC_WORD = 32'h494E_4458;
   localparam logic [31:0] VER_0100   = 32'h3031_3030;
   localparam logic [31:0] VER_0200   = 32'h3032_3030;
   localparam logic [31:0] VER_0300   = 32'h3033_3030;

   // Header layout in bytes.
   localparam logic [31:0] POS_MAGIC_LAST   = 32'd3;
   localparam logic [31:0] POS_VERSION_LAST = 32'd7;
   localparam logic [31:0] POS_OFFSET_LAST  = 32'd11;
   localparam logic [31:0] MIN_TABLE_OFFSET = 32'd12;

   // Result queue depth; two results may be pushed per beat.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
      logic       file_end;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [1:0]  obj_code;
      logic [1:0]  access_code;
      logic [1:0]  playback_type;
      logic [15:0] movie_object_id;
      logic [39:0] object_file_name;
      logic [15:0] title_index;
      logic [1:0]  version_code;
      logic [2:0]  error_code;
      logic        last_in_run;
   } rsp_payload_type;

   // Up to two results produced by one accepted beat, in order.
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } push_type;

endpackage

`default_nettype wire

@@ rtl/dit_stream_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
// Depends on dit_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface dit_req_if;
   logic                     valid;
   logic                     ready;
   dit_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dit_rsp_if;
   logic                     valid;
   logic                     ready;
   dit_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/disc_index_table_parser.sv @@
// Disc index table parser: one file byte per beat in, parsed records out.
// One byte is taken per cycle while the result queue has room for two more results;
// a byte that causes two results takes two output beats. Each result is registered
// in that queue before rsp_stream offers it. Reset (synchronous, active high) returns
// the parser to waiting for a file start and empties the result queue.
`timescale 1ns / 1ps
`default_nettype none

module disc_index_table_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   dit_req_if.sink    req_stream,
   dit_rsp_if.source  rsp_stream
);

   // The parser updates its state registers on every accepted byte beat and
   // pushes zero, one or two results into the queue in the same cycle. The
   // queue registers the results, so the response side sees only flops.
   //
   // A byte is taken whenever the queue has space for two more results. That
   // decision depends only on the registered fill level, so the request ready
   // never waits on the response ready in the same cycle, and a byte can be
   // taken while earlier results still wait to be collected. With one result
   // or none per byte and rsp_stream ready, one byte is taken every cycle.

   dit_pkg::push_type push;
   logic              room;
   logic              beat;

   assign req_stream.ready = room;
   assign beat             = req_stream.valid && room;

   dit_parser u_parser (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .req   (req_stream.payload),
      .push  (push)
   );

   // Results leave strictly in the order the parser produced them; the last
   // result caused by a byte already carries its last_in_run mark.
   dit_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .out_valid   (rsp_stream.valid),
      .out_ready   (rsp_stream.ready),
      .out_payload (rsp_stream.payload)
   );

endmodule

`default_nettype wire

@@ rtl/dit_parser.sv @@
// Parser core: state registers and per-beat next-state and result logic.
// Depends on dit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dit_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     beat,
   input  wire dit_pkg::req_payload_type req,
   output dit_pkg::push_type             push
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SKIP,
      PH_LENGTH,
      PH_FIRST_PLAY,
      PH_TOP_MENU,
      PH_COUNT,
      PH_TITLE,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] offset_ff, offset_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] shift_ff, shift_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] seen_ff, seen_in;
   logic [1:0]  version_ff, version_in;

   function automatic dit_pkg::rsp_payload_type plain_result(logic [2:0] kind,
                                                             logic [2:0] err);
      dit_pkg::rsp_payload_type r;
      r             = '0;
      r.record_kind = kind;
      r.error_code  = err;
      return r;
   endfunction

   always_comb begin
      phase_type                cur_phase;
      logic [31:0]              cur_pos;
      logic [31:0]              cur_offset;
      logic [3:0]               cur_count;
      logic [63:0]              cur_shift;
      logic [15:0]              cur_total;
      logic [15:0]              cur_seen;
      logic [1:0]               cur_version;
      logic [1:0]               obj;
      logic                     rec_done;
      logic                     main_valid;
      logic                     add_finish;
      logic                     trunc;
      dit_pkg::rsp_payload_type main_res;
      dit_pkg::rsp_payload_type rec_res;
      dit_pkg::push_type        p;

      // A file start discards all earlier state.
      if (req.file_start) begin
         cur_phase   = PH_HEADER;
         cur_pos     = '0;
         cur_offset  = '0;
         cur_count   = '0;
         cur_shift   = '0;
         cur_total   = '0;
         cur_seen    = '0;
         cur_version = '0;
      end else begin
         cur_phase   = phase_ff;
         cur_pos     = pos_ff;
         cur_offset  = offset_ff;
         cur_count   = count_ff;
         cur_shift   = shift_ff;
         cur_total   = total_ff;
         cur_seen    = seen_ff;
         cur_version = version_ff;
      end

      phase_in   = cur_phase;
      pos_in     = cur_pos;
      offset_in  = cur_offset;
      count_in   = cur_count;
      shift_in   = cur_shift;
      total_in   = cur_total;
      seen_in    = cur_seen;
      version_in = cur_version;

      main_valid = 1'b0;
      add_finish = 1'b0;
      trunc      = 1'b0;
      main_res   = '0;
      rec_done   = 1'b0;

      unique case (cur_phase)
         PH_HEADER: begin
            shift_in = {32'd0, cur_shift[23:0], req.data_byte};
            if (cur_pos == dit_pkg::POS_MAGIC_LAST && shift_in[31:0] != dit_pkg::MAGIC_WORD)
            begin
               phase_in   = PH_ERROR;
               main_valid = 1'b1;
               main_res   = plain_result(dit_pkg::KIND_ERROR, dit_pkg::ERR_MAGIC);
            end else if (cur_pos == dit_pkg::POS_VERSION_LAST) begin
               if (shift_in[31:0] == dit_pkg::VER_0100) begin
                  version_in = dit_pkg::VER_CODE_0100;
               end else if (shift_in[31:0] == dit_pkg::VER_0200) begin
                  version_in = dit_pkg::VER_CODE_0200;
               end else if (shift_in[31:0] == dit_pkg::VER_0300) begin
                  version_in = dit_pkg::VER_CODE_0300;
               end else begin
                  phase_in   = PH_ERROR;
                  main_valid = 1'b1;
                  main_res   = plain_result(dit_pkg::KIND_ERROR, dit_pkg::ERR_VERSION);
               end
            end else if (cur_pos == dit_pkg::POS_OFFSET_LAST) begin
               offset_in = shift_in[31:0];
               count_in  = '0;
               if (shift_in[31:0] < dit_pkg::MIN_TABLE_OFFSET) begin
                  phase_in   = PH_ERROR;
                  main_valid = 1'b1;
                  main_res   = plain_result(dit_pkg::KIND_ERROR, dit_pkg::ERR_OFFSET);
               end else if (shift_in[31:0] == dit_pkg::MIN_TABLE_OFFSET) begin
                  phase_in = PH_LENGTH;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if ({1'b0, cur_pos} + 33'd1 == {1'b0, cur_offset}) begin
               phase_in = PH_LENGTH;
               count_in = '0;
            end
         end
         PH_LENGTH: begin
            if (cur_count >= 4'd3) begin
               count_in = '0;
               phase_in = PH_FIRST_PLAY;
            end else begin
               count_in = cur_count + 4'd1;
            end
         end
         PH_FIRST_PLAY, PH_TOP_MENU, PH_TITLE: begin
            // Byte 0 lands in the top byte; bytes 4 to 10 shift in below it.
            if (cur_count == 4'd0) begin
               shift_in = {req.data_byte, 56'd0};
            end else if (cur_count >= 4'd4 && cur_count <= 4'd10) begin
               shift_in = {cur_shift[63:56], cur_shift[47:0], req.data_byte};
            end
            if (cur_count == 4'd3 && cur_shift[63:62] != dit_pkg::OBJ_MOVIE &&
                cur_shift[63:62] != dit_pkg::OBJ_APP) begin
               phase_in   = PH_ERROR;
               main_valid = 1'b1;
               main_res   = plain_result(dit_pkg::KIND_ERROR, dit_pkg::ERR_OBJ_TYPE);
            end else if (cur_count >= 4'd11) begin
               count_in = '0;
               rec_done = 1'b1;
            end else begin
               count_in = cur_count + 4'd1;
            end
         end
         PH_COUNT: begin
            total_in = {cur_total[7:0], req.data_byte};
            if (cur_count >= 4'd1) begin
               count_in = '0;
               seen_in  = '0;
               if (total_in == 16'd0) begin
                  phase_in   = PH_DONE;
                  main_valid = 1'b1;
                  main_res   = plain_result(dit_pkg::KIND_FINISHED, dit_pkg::ERR_NONE);
               end else begin
                  phase_in = PH_TITLE;
               end
            end else begin
               count_in = 4'd1;
            end
         end
         default: begin
         end
      endcase

      // Completed record fields.
      obj                      = shift_in[63:62];
      rec_res                  = '0;
      rec_res.obj_code         = obj;
      rec_res.access_code      = (cur_phase == PH_TITLE) ? shift_in[61:60] : 2'd0;
      rec_res.playback_type    = (cur_phase == PH_TOP_MENU) ? 2'd0 : shift_in[55:54];
      rec_res.movie_object_id  = (obj == dit_pkg::OBJ_MOVIE) ? shift_in[39:24] : 16'd0;
      rec_res.object_file_name = (obj == dit_pkg::OBJ_MOVIE) ? 40'd0 : shift_in[39:0];

      if (rec_done) begin
         main_valid = 1'b1;
         main_res   = rec_res;
         unique case (cur_phase)
            PH_FIRST_PLAY: begin
               main_res.record_kind = dit_pkg::KIND_FIRST_PLAY;
               phase_in             = PH_TOP_MENU;
            end
            PH_TOP_MENU: begin
               main_res.record_kind = dit_pkg::KIND_TOP_MENU;
               phase_in             = PH_COUNT;
               total_in             = '0;
            end
            default: begin
               main_res.record_kind = dit_pkg::KIND_TITLE;
               main_res.title_index = cur_seen;
               seen_in              = cur_seen + 16'd1;
               if (seen_in == cur_total) begin
                  phase_in   = PH_DONE;
                  add_finish = 1'b1;
               end
            end
         endcase
      end

      // Any byte that leaves parsing active advances the position.
      if (phase_in != PH_IDLE && phase_in != PH_DONE && phase_in != PH_ERROR) begin
         pos_in = cur_pos + 32'd1;
         if (req.file_end) begin
            phase_in = PH_ERROR;
            trunc    = 1'b1;
         end
      end

      p = '0;
      if (main_valid) begin
         p.first = main_res;
         if (add_finish) begin
            p.second = plain_result(dit_pkg::KIND_FINISHED, dit_pkg::ERR_NONE);
            p.count  = 2'd2;
         end else if (trunc) begin
            p.second = plain_result(dit_pkg::KIND_ERROR, dit_pkg::ERR_TRUNCATED);
            p.count  = 2'd2;
         end else begin
            p.count = 2'd1;
         end
      end else if (trunc) begin
         p.first = plain_result(dit_pkg::KIND_ERROR, dit_pkg::ERR_TRUNCATED);
         p.count = 2'd1;
      end
      p.first.version_code  = version_in;
      p.second.version_code = version_in;
      p.first.last_in_run   = (p.count == 2'd1);
      p.second.last_in_run  = 1'b1;
      if (!beat) begin
         p.count = 2'd0;
      end
      push = p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pos_ff     <= '0;
         offset_ff  <= '0;
         count_ff   <= '0;
         shift_ff   <= '0;
         total_ff   <= '0;
         seen_ff    <= '0;
         version_ff <= '0;
      end else if (beat) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         offset_ff  <= offset_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
         total_ff   <= total_in;
         seen_ff    <= seen_in;
         version_ff <= version_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dit_rsp_queue.sv @@
// Small result queue: takes up to two results per cycle, hands out one per beat.
// Depends on dit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dit_rsp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dit_pkg::push_type         push,
   output logic                           room,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output dit_pkg::rsp_payload_type       out_payload
);

   localparam int PTR_W = $clog2(dit_pkg::QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   dit_pkg::rsp_payload_type entry_ff [dit_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             pop;

   assign out_valid   = (fill_ff != '0);
   assign out_payload = entry_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   // Room for the largest burst one beat can cause.
   assign room        = (fill_ff <= CNT_W'(dit_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      fill_in   = fill_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

@@ sim/disc_index_table_parser_tb.sv @@
// Self-checking testbench for disc_index_table_parser: drives index file bytes on the request
// channel and checks every result against an in-bench model of the parser or the directed table.
// Depends on dit_pkg, the dit_req_if/dit_rsp_if channel interfaces and the parser RTL.
`timescale 1ns / 1ps

module disc_index_table_parser_tb;
   import dit_pkg::*;

   // Error code field value carried by every result that is not an error.
   localparam logic [2:0] NO_ERROR = 3'd0;

   // Object type codes that a record must never carry.
   localparam logic [1:0] OBJ_NONE     = 2'b00;
   localparam logic [1:0] OBJ_RESERVED = 2'b11;

   localparam int DIRECTED_ROWS = 27;
   // Bytes sent after the directed table, for about 1550 bytes in all.
   localparam int RANDOM_BYTES  = 1520;
   // Extra cycles waited once every expected result is in, to cover the result queue.
   localparam int DRAIN_CYCLES  = 8;
   localparam int MAX_REPORTS   = 25;

   // Parser phases, kept in file order so that a range compare finds the active ones.
   typedef enum logic [3:0] {
      PH_IDLE, PH_HEADER, PH_SKIP, PH_LENGTH, PH_FIRST_PLAY, PH_TOP_MENU, PH_COUNT,
      PH_TITLE, PH_DONE, PH_ERROR
   } parse_phase_type;

   // Receiver back-pressure patterns.
   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG
   } stall_mode_type;

   // One row of the directed table. Rows with typed set carry the single result that the
   // byte must produce; the other rows are checked against the model.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
      logic       file_end;
      logic       typed;
      logic [2:0] kind;
      logic [2:0] err;
      logic [1:0] ver;
   } directed_row_type;

   logic clock;
   logic reset;

   dit_req_if req_if ();
   dit_rsp_if rsp_if ();

   disc_index_table_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   // Model state of the parser.
   parse_phase_type parse_phase;
   logic [31:0]     byte_pos;
   logic [31:0]     table_offset;
   logic [3:0]      rec_count;
   logic [63:0]     rec_shift;
   logic [15:0]     title_total;
   logic [15:0]     titles_seen;
   logic [1:0]      version_seen;

   // Results that the parser still owes, oldest first.
   rsp_payload_type expected_records [$];

   // Bytes of the file being built for the random part.
   logic [7:0] file_image [$];

   directed_row_type directed_rows [DIRECTED_ROWS];

   int  mismatches;
   int  parsed_bytes;
   int  sent_bytes;
   int  files_sent;
   int  record_results;
   int  finished_results;
   int  error_results;
   int  burst_left;
   bit  steady_sender;
   rsp_payload_type want_record;

   // ------------------------------------------------------------------------------------------
   // Model of the parser.
   // ------------------------------------------------------------------------------------------

   function automatic void reset_predictor();
      parse_phase  = PH_IDLE;
      byte_pos     = '0;
      table_offset = '0;
      rec_count    = '0;
      rec_shift    = '0;
      title_total  = '0;
      titles_seen  = '0;
      version_seen = VER_CODE_0100;
   endfunction

   // Every result carries the version known at the moment it is produced.
   function automatic rsp_payload_type make_result(logic [2:0] kind, logic [1:0] obj,
         logic [1:0] acc, logic [1:0] pb, logic [15:0] mid, logic [39:0] name,
         logic [15:0] tnum, logic [2:0] err);
      rsp_payload_type r;
      r.record_kind      = kind;
      r.obj_code         = obj;
      r.access_code      = acc;
      r.playback_type    = pb;
      r.movie_object_id  = mid;
      r.object_file_name = name;
      r.title_index      = tnum;
      r.version_code     = version_seen;
      r.error_code       = err;
      r.last_in_run      = 1'b0;
      return r;
   endfunction

   function automatic void add_result(inout push_type run, input rsp_payload_type r);
      if (run.count == 2'd0) begin
         run.first = r;
      end else begin
         run.second = r;
      end
      run.count = run.count + 2'd1;
   endfunction

   function automatic void raise_error(inout push_type run, input logic [2:0] err);
      parse_phase = PH_ERROR;
      add_result(run, make_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, err));
   endfunction

   // Decodes the completed record held in rec_shift. Byte 0 sits in the top byte and
   // bytes 4..10 fill the low 56 bits, so byte 6 starts at bit 39.
   function automatic rsp_payload_type record_result(logic [2:0] kind, logic [15:0] tnum);
      logic [1:0]  obj;
      logic [1:0]  acc;
      logic [1:0]  pb;
      logic [15:0] mid;
      logic [39:0] name;
      obj  = rec_shift[63:62];
      acc  = (kind == KIND_TITLE) ? rec_shift[61:60] : 2'd0;
      pb   = (kind == KIND_TOP_MENU) ? 2'd0 : rec_shift[55:54];
      mid  = (obj == OBJ_MOVIE) ? rec_shift[39:24] : 16'd0;
      name = (obj == OBJ_MOVIE) ? 40'd0 : rec_shift[39:0];
      return make_result(kind, obj, acc, pb, mid, name, tnum, NO_ERROR);
   endfunction

   // Advances the model by one accepted byte and returns the results it causes, in order.
   function automatic push_type parse_index_byte(logic [7:0] b, logic start, logic fin);
      push_type   run;
      logic [1:0] obj_bits;
      logic       record_done;
      run = '0;
      if (start) begin
         reset_predictor();
         parse_phase = PH_HEADER;
      end
      case (parse_phase)
         PH_HEADER: begin
            // Magic, version and offset words all go through the low 32 bits.
            rec_shift = {32'd0, rec_shift[23:0], b};
            if (byte_pos == POS_MAGIC_LAST && rec_shift[31:0] != MAGIC_WORD) begin
               raise_error(run, ERR_MAGIC);
            end else if (byte_pos == POS_VERSION_LAST) begin
               if (rec_shift[31:0] == VER_0100) begin
                  version_seen = VER_CODE_0100;
               end else if (rec_shift[31:0] == VER_0200) begin
                  version_seen = VER_CODE_0200;
               end else if (rec_shift[31:0] == VER_0300) begin
                  version_seen = VER_CODE_0300;
               end else begin
                  raise_error(run, ERR_VERSION);
               end
            end else if (byte_pos == POS_OFFSET_LAST) begin
               table_offset = rec_shift[31:0];
               if (table_offset < MIN_TABLE_OFFSET) begin
                  raise_error(run, ERR_OFFSET);
               end else if (table_offset == MIN_TABLE_OFFSET) begin
                  parse_phase = PH_LENGTH;
               end else begin
                  parse_phase = PH_SKIP;
               end
               rec_count = '0;
            end
         end
         PH_SKIP: begin
            if ({1'b0, byte_pos} + 33'd1 == {1'b0, table_offset}) begin
               parse_phase = PH_LENGTH;
               rec_count   = '0;
            end
         end
         PH_LENGTH: begin
            if (rec_count >= 4'd3) begin
               rec_count   = '0;
               parse_phase = PH_FIRST_PLAY;
            end else begin
               rec_count++;
            end
         end
         PH_FIRST_PLAY, PH_TOP_MENU, PH_TITLE: begin
            record_done = 1'b0;
            // Bytes 1..3 and 11 are not kept; byte 0 and bytes 4..10 are.
            if (rec_count == 4'd0) begin
               rec_shift = {b, 56'd0};
            end else if (rec_count >= 4'd4 && rec_count <= 4'd10) begin
               rec_shift = {rec_shift[63:56], rec_shift[47:0], b};
            end
            obj_bits = rec_shift[63:62];
            if (rec_count == 4'd3 && obj_bits != OBJ_MOVIE && obj_bits != OBJ_APP) begin
               raise_error(run, ERR_OBJ_TYPE);
            end else if (rec_count >= 4'd11) begin
               rec_count   = '0;
               record_done = 1'b1;
            end else begin
               rec_count++;
            end
            if (record_done) begin
               if (parse_phase == PH_FIRST_PLAY) begin
                  add_result(run, record_result(KIND_FIRST_PLAY, 16'd0));
                  parse_phase = PH_TOP_MENU;
               end else if (parse_phase == PH_TOP_MENU) begin
                  add_result(run, record_result(KIND_TOP_MENU, 16'd0));
                  parse_phase = PH_COUNT;
                  title_total = '0;
               end else begin
                  add_result(run, record_result(KIND_TITLE, titles_seen));
                  titles_seen++;
                  if (titles_seen == title_total) begin
                     parse_phase = PH_DONE;
                     add_result(run, make_result(KIND_FINISHED, '0, '0, '0, '0, '0, '0,
                                                 NO_ERROR));
                  end
               end
            end
         end
         PH_COUNT: begin
            title_total = {title_total[7:0], b};
            if (rec_count >= 4'd1) begin
               rec_count   = '0;
               titles_seen = '0;
               if (title_total == 16'd0) begin
                  parse_phase = PH_DONE;
                  add_result(run, make_result(KIND_FINISHED, '0, '0, '0, '0, '0, '0,
                                              NO_ERROR));
               end else begin
                  parse_phase = PH_TITLE;
               end
            end else begin
               rec_count = 4'd1;
            end
         end
         default: begin
         end
      endcase
      // An end mark only counts while the file is still being parsed, so a failed check or
      // a finished table on the same byte wins over truncation.
      if (parse_phase >= PH_HEADER && parse_phase <= PH_TITLE) begin
         byte_pos++;
         if (fin) begin
            raise_error(run, ERR_TRUNCATED);
         end
      end
      if (run.count == 2'd2) begin
         run.second.last_in_run = 1'b1;
      end else if (run.count == 2'd1) begin
         run.first.last_in_run = 1'b1;
      end
      return run;
   endfunction

   // ------------------------------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < MAX_REPORTS) begin
         $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                  want);
      end
      mismatches++;
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Every result beat is matched against the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_records.size() == 0) begin
            report_mismatch("record_kind of a result with nothing expected",
                            rsp_if.payload.record_kind, 0);
         end else begin
            want_record = expected_records.pop_front();
            check_field("record_kind", rsp_if.payload.record_kind, want_record.record_kind);
            check_field("obj_code", rsp_if.payload.obj_code, want_record.obj_code);
            check_field("access_code", rsp_if.payload.access_code, want_record.access_code);
            check_field("playback_type", rsp_if.payload.playback_type,
                        want_record.playback_type);
            check_field("movie_object_id", rsp_if.payload.movie_object_id,
                        want_record.movie_object_id);
            check_field("object_file_name", rsp_if.payload.object_file_name,
                        want_record.object_file_name);
            check_field("title_index", rsp_if.payload.title_index, want_record.title_index);
            check_field("version_code", rsp_if.payload.version_code, want_record.version_code);
            check_field("error_code", rsp_if.payload.error_code, want_record.error_code);
            check_field("last_in_run", rsp_if.payload.last_in_run, want_record.last_in_run);
            if (want_record.record_kind == KIND_ERROR) begin
               error_results++;
            end else if (want_record.record_kind == KIND_FINISHED) begin
               finished_results++;
            end else begin
               record_results++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------------------------

   // Offers one byte as a beat and waits for it to be taken. The sender works in bursts;
   // between bursts it drops valid unless it is in a steady stretch.
   // The model runs at the accepting edge. A directed row may supply the result itself.
   task automatic send_byte(logic [7:0] b, logic start, logic fin, bit use_typed,
                            rsp_payload_type typed_result);
      push_type run;
      bit       active;
      if (burst_left == 0) begin
         if (!steady_sender) begin
            repeat ($urandom_range(1, 5)) begin
               @(negedge clock);
               req_if.valid <= 1'b0;
            end
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.payload <= '{data_byte: b, file_start: start, file_end: fin};
      do begin
         @(posedge clock);
      end while (req_if.ready !== 1'b1);
      active = start || (parse_phase >= PH_HEADER && parse_phase <= PH_TITLE);
      run = parse_index_byte(b, start, fin);
      sent_bytes++;
      if (active) begin
         parsed_bytes++;
      end
      if (use_typed) begin
         expected_records.push_back(typed_result);
      end else begin
         if (run.count >= 2'd1) begin
            expected_records.push_back(run.first);
         end
         if (run.count == 2'd2) begin
            expected_records.push_back(run.second);
         end
      end
   endtask

   // Stops sending and waits until the parser has delivered everything it owes.
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_records.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void append_word(logic [31:0] w);
      for (int i = 3; i >= 0; i--) begin
         file_image.push_back(w[i*8 +: 8]);
      end
   endfunction

   function automatic void append_random(int count);
      logic [7:0] value;
      for (int i = 0; i < count; i++) begin
         value = 8'($urandom_range(0, 255));
         file_image.push_back(value);
      end
   endfunction

   // A 12-byte object record, now and then with an object type that is not allowed.
   function automatic void append_record();
      logic [1:0] obj;
      logic [5:0] low_bits;
      if ($urandom_range(0, 49) == 0) begin
         obj = $urandom_range(0, 1) ? OBJ_NONE : OBJ_RESERVED;
      end else begin
         obj = $urandom_range(0, 1) ? OBJ_MOVIE : OBJ_APP;
      end
      low_bits = 6'($urandom_range(0, 63));
      file_image.push_back({obj, low_bits});
      append_random(11);
   endfunction

   // Builds one index file and sends it. Most files are well formed with random content;
   // the rest carry a bad magic, version, offset or object type, are cut short, lose their
   // end mark (so the next file start lands mid-parse), or are followed by stray bytes.
   task automatic send_random_file();
      logic [31:0] magic;
      logic [31:0] version_word;
      logic [31:0] offset;
      logic [15:0] titles;
      int          flaw;
      int          flip_bit;
      int          cut_at;
      bit          must_cut;
      bit          end_mark;
      file_image.delete();
      flaw     = $urandom_range(0, 99);
      must_cut = 1'b0;
      magic    = MAGIC_WORD;
      if (flaw < 3) begin
         flip_bit        = $urandom_range(0, 31);
         magic[flip_bit] = ~magic[flip_bit];
      end
      case ($urandom_range(0, 2))
         0:       version_word = VER_0100;
         1:       version_word = VER_0200;
         default: version_word = VER_0300;
      endcase
      if (flaw >= 3 && flaw < 6) begin
         flip_bit               = $urandom_range(0, 31);
         version_word[flip_bit] = ~version_word[flip_bit];
      end
      if (flaw >= 6 && flaw < 9) begin
         offset = $urandom_range(0, 11);
      end else if (flaw >= 9 && flaw < 12) begin
         // Any 32-bit offset; the file is cut long before a far one could be reached.
         offset   = $urandom();
         must_cut = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         offset = MIN_TABLE_OFFSET;
      end else begin
         offset = MIN_TABLE_OFFSET + $urandom_range(1, 6);
      end
      append_word(magic);
      append_word(version_word);
      append_word(offset);
      if (offset >= MIN_TABLE_OFFSET && offset <= 32'd40) begin
         append_random(offset - MIN_TABLE_OFFSET);
      end else begin
         append_random(8);
      end
      append_random(4);
      append_record();
      append_record();
      if (flaw >= 12 && flaw < 15) begin
         titles   = 16'($urandom());
         must_cut = 1'b1;
      end else begin
         titles = 16'($urandom_range(0, 4));
      end
      file_image.push_back(titles[15:8]);
      file_image.push_back(titles[7:0]);
      repeat ((titles > 16'd4) ? 3 : titles) append_record();
      if ($urandom_range(0, 3) == 0) begin
         append_random($urandom_range(1, 3));
      end
      if (must_cut || $urandom_range(0, 9) == 0) begin
         cut_at = $urandom_range(1, file_image.size());
      end else begin
         cut_at = file_image.size();
      end
      end_mark = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < cut_at; i++) begin
         send_byte(file_image[i], i == 0, end_mark && i == cut_at - 1, 1'b0, '0);
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end
      files_sent++;
   endtask

   function automatic directed_row_type plain_row(logic [7:0] b, logic start, logic fin);
      return '{data_byte: b, file_start: start, file_end: fin, typed: 1'b0,
               kind: KIND_FIRST_PLAY, err: NO_ERROR, ver: VER_CODE_0100};
   endfunction

   function automatic directed_row_type typed_row(logic [7:0] b, logic start, logic fin,
         logic [2:0] kind, logic [2:0] err, logic [1:0] ver);
      return '{data_byte: b, file_start: start, file_end: fin, typed: 1'b1,
               kind: kind, err: err, ver: ver};
   endfunction

   // ------------------------------------------------------------------------------------------
   // Clock, receiver and run control.
   // ------------------------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver switches between patterns: always ready, random ready, periodic
   // ready, and long stalls with short open windows.
   initial begin : receiver
      int             cycle_count;
      int             hold_left;
      bit             level;
      stall_mode_type stall_mode;
      rsp_if.ready = 1'b0;
      cycle_count  = 0;
      hold_left    = 0;
      level        = 1'b1;
      stall_mode   = STALL_NONE;
      forever begin
         @(negedge clock);
         if (cycle_count % 300 == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
         cycle_count++;
         case (stall_mode)
            STALL_NONE:     level = 1'b1;
            STALL_RANDOM:   level = ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: level = (cycle_count % 3 == 0);
            default: begin
               if (hold_left == 0) begin
                  level     = !level;
                  hold_left = level ? $urandom_range(1, 4) : $urandom_range(1, 15);
               end
               hold_left--;
            end
         endcase
         rsp_if.ready <= level;
      end
   end

   // Hard limit on the run, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("disc_index_table_parser_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      directed_row_type row;
      rsp_payload_type  typed_want;
      int               random_target;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      mismatches       = 0;
      parsed_bytes     = 0;
      sent_bytes       = 0;
      files_sent       = 0;
      record_results   = 0;
      finished_results = 0;
      error_results    = 0;
      burst_left       = 0;
      steady_sender    = 1'b0;
      reset_predictor();

      // Directed part: stray bytes before any file start (all ones and an end mark among
      // them), a bad magic, a file that ends on its first byte, a bad version and an offset
      // that points back into the header.
      directed_rows = '{
         plain_row(8'h00, 1'b0, 1'b0),
         plain_row(8'hFF, 1'b0, 1'b1),
         plain_row("I", 1'b1, 1'b0),
         plain_row("N", 1'b0, 1'b0),
         plain_row("D", 1'b0, 1'b0),
         typed_row("Y", 1'b0, 1'b0, KIND_ERROR, ERR_MAGIC, VER_CODE_0100),
         typed_row("I", 1'b1, 1'b1, KIND_ERROR, ERR_TRUNCATED, VER_CODE_0100),
         plain_row("I", 1'b1, 1'b0),
         plain_row("N", 1'b0, 1'b0),
         plain_row("D", 1'b0, 1'b0),
         plain_row("X", 1'b0, 1'b0),
         plain_row("0", 1'b0, 1'b0),
         plain_row("4", 1'b0, 1'b0),
         plain_row("0", 1'b0, 1'b0),
         typed_row("0", 1'b0, 1'b0, KIND_ERROR, ERR_VERSION, VER_CODE_0100),
         plain_row("I", 1'b1, 1'b0),
         plain_row("N", 1'b0, 1'b0),
         plain_row("D", 1'b0, 1'b0),
         plain_row("X", 1'b0, 1'b0),
         plain_row("0", 1'b0, 1'b0),
         plain_row("3", 1'b0, 1'b0),
         plain_row("0", 1'b0, 1'b0),
         plain_row("0", 1'b0, 1'b0),
         plain_row(8'h00, 1'b0, 1'b0),
         plain_row(8'h00, 1'b0, 1'b0),
         plain_row(8'h00, 1'b0, 1'b0),
         typed_row(8'h0B, 1'b0, 1'b0, KIND_ERROR, ERR_OFFSET, VER_CODE_0300)
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row        = directed_rows[i];
         typed_want = '0;
         typed_want.record_kind  = row.kind;
         typed_want.error_code   = row.err;
         typed_want.version_code = row.ver;
         typed_want.last_in_run  = 1'b1;
         send_byte(row.data_byte, row.file_start, row.file_end, row.typed, typed_want);
      end
      drain_results();

      // Random part: whole files, now and then with every result drained before the next.
      random_target = sent_bytes + RANDOM_BYTES;
      while (sent_bytes < random_target) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         send_random_file();
         if (files_sent % 10 == 0) begin
            drain_results();
         end
      end
      drain_results();

      $display("Sent %0d bytes in %0d random files after the directed table; %0d were parsed.",
               sent_bytes, files_sent, parsed_bytes);
      $display("Checked %0d records, %0d finished tables and %0d error results.",
               record_results, finished_results, error_results);
      if (mismatches == 0) begin
         $display("disc_index_table_parser_tb: PASS");
      end else begin
         $display("disc_index_table_parser_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dit_pkg.sv
rtl/dit_stream_if.sv
rtl/dit_parser.sv
rtl/dit_rsp_queue.sv
rtl/disc_index_table_parser.sv
sim/disc_index_table_parser_tb.sv
